// ===== src/bmpbin_pkg.sv =====
// shared constants, result type and defaults for the bmp binarizer
package bmpbin_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 4;
  localparam int COORD_W  = 12;
  localparam int WORD_W   = 32;

  // luminance in thousandths: 1000 * 255 needs 18 bits
  localparam int LUMA_W = 18;
  localparam logic [9:0] COEF_R = 10'd299;
  localparam logic [9:0] COEF_G = 10'd587;
  localparam logic [9:0] COEF_B = 10'd114;
  localparam logic [9:0] LUMA_SCALE = 10'd1000;
  localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd128;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [WORD_W-1:0] HEADER_LEN = 32'd54;

  // header byte positions
  localparam logic [5:0] POS_SIG_LAST   = 6'd1;
  localparam logic [5:0] POS_OFFSET     = 6'd10;
  localparam logic [5:0] POS_FILE_END   = 6'd13;
  localparam logic [5:0] POS_WIDTH      = 6'd18;
  localparam logic [5:0] POS_HEIGHT     = 6'd22;
  localparam logic [5:0] POS_PLANES     = 6'd26;
  localparam logic [5:0] POS_DEPTH      = 6'd28;
  localparam logic [5:0] POS_COMPRESS   = 6'd30;
  localparam logic [5:0] POS_HEADER_END = 6'd53;

  localparam logic [STATUS_W-1:0] ST_PIXEL      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_SIGNATURE  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT_HDR  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_DEPTH      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_COMPRESSED = 4'd4;
  localparam logic [STATUS_W-1:0] ST_PLANES     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_SIZE       = 4'd6;
  localparam logic [STATUS_W-1:0] ST_OFFSET     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 4'd8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pixel_white;
    logic [COORD_W-1:0]  pixel_row;
    logic [COORD_W-1:0]  pixel_column;
    logic                last_pixel;
  } result_t;

endpackage

// ===== src/bmpbin_in_if.sv =====
// byte stream channel carrying file bytes into the binarizer
interface bmpbin_in_if;
  import bmpbin_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

// ===== src/bmpbin_out_if.sv =====
// result channel carrying thresholded pixels and error codes
interface bmpbin_out_if;
  import bmpbin_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                pixel_white;
  logic [COORD_W-1:0]  pixel_row;
  logic [COORD_W-1:0]  pixel_column;
  logic                last_pixel;

  modport source (output valid, output status, output pixel_white, output pixel_row,
                  output pixel_column, output last_pixel, input ready);
  modport sink (input valid, input status, input pixel_white, input pixel_row,
                input pixel_column, input last_pixel, output ready);
endinterface

// ===== src/bmpbin_luma.sv =====
// weighted luminance of one bgr pixel compared against the scaled threshold
module bmpbin_luma (
  input  logic [bmpbin_pkg::BYTE_W-1:0] blue,
  input  logic [bmpbin_pkg::BYTE_W-1:0] green,
  input  logic [bmpbin_pkg::BYTE_W-1:0] red,
  input  logic [bmpbin_pkg::LUMA_W-1:0] threshold_scaled,
  output logic                          white
);
  import bmpbin_pkg::*;

  logic [LUMA_W-1:0] luma;

  assign luma = LUMA_W'(red) * LUMA_W'(COEF_R)
              + LUMA_W'(green) * LUMA_W'(COEF_G)
              + LUMA_W'(blue) * LUMA_W'(COEF_B);

  assign white = (luma >= threshold_scaled);
endmodule

// ===== src/bmpbin_ctrl.sv =====
// header parser, skip counter and pixel assembly for one byte per transfer
module bmpbin_ctrl #(
  parameter int MAX_WIDTH  = bmpbin_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpbin_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [bmpbin_pkg::BYTE_W-1:0] file_byte,
  input  logic                          end_of_file,
  input  logic [bmpbin_pkg::LUMA_W-1:0] threshold_scaled,
  output logic                          res_valid,
  output bmpbin_pkg::result_t           res
);
  import bmpbin_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t            phase, phase_next;
  logic [WORD_W-1:0] byte_position, byte_position_next;
  logic [WORD_W-1:0] pixel_offset, pixel_offset_next;
  logic [WORD_W-1:0] raw_width, raw_width_next;
  logic [WORD_W-1:0] raw_height, raw_height_next;
  logic [15:0]       signature, signature_next;
  logic [15:0]       planes, planes_next;
  logic [15:0]       depth, depth_next;
  logic              compressed, compressed_next;
  logic [WB-1:0]     image_width, image_width_next;
  logic [HB-1:0]     image_height, image_height_next;
  logic              bottom_up, bottom_up_next;
  logic [BYTE_W-1:0] blue_byte, blue_byte_next;
  logic [BYTE_W-1:0] green_byte, green_byte_next;
  logic [1:0]        byte_in_pixel, byte_in_pixel_next;
  logic [WB-1:0]     column_count, column_count_next;
  logic [HB-1:0]     row_count, row_count_next;
  logic [1:0]        padding_left, padding_left_next;

  logic [5:0]        hdr_pos;
  logic [WORD_W-1:0] height_mag;
  logic [STATUS_W-1:0] hdr_code;
  logic              white;
  logic [WB-1:0]     column_inc;
  logic [HB-1:0]     row_inc;
  logic [HB-1:0]     row_out;
  logic              do_pixel;

  bmpbin_luma u_luma (
    .blue             (blue_byte),
    .green            (green_byte),
    .red              (file_byte),
    .threshold_scaled (threshold_scaled),
    .white            (white)
  );

  assign hdr_pos    = byte_position[5:0];
  assign height_mag = raw_height[WORD_W-1] ? (~raw_height + 1'b1) : raw_height;
  assign column_inc = column_count + 1'b1;
  assign row_inc    = row_count + 1'b1;
  assign row_out    = bottom_up ? (image_height - row_inc) : row_count;

  // first failing header check, in priority order
  always_comb begin
    if (depth != BMP_DEPTH) begin
      hdr_code = ST_DEPTH;
    end else if (compressed) begin
      hdr_code = ST_COMPRESSED;
    end else if (planes != BMP_PLANES) begin
      hdr_code = ST_PLANES;
    end else if (raw_width == '0 || raw_width > WORD_W'(MAX_WIDTH)) begin
      hdr_code = ST_SIZE;
    end else if (height_mag == '0 || height_mag > WORD_W'(MAX_HEIGHT)) begin
      hdr_code = ST_SIZE;
    end else if (pixel_offset < HEADER_LEN) begin
      hdr_code = ST_OFFSET;
    end else begin
      hdr_code = ST_PIXEL;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    pixel_offset_next  = pixel_offset;
    raw_width_next     = raw_width;
    raw_height_next    = raw_height;
    signature_next     = signature;
    planes_next        = planes;
    depth_next         = depth;
    compressed_next    = compressed;
    image_width_next   = image_width;
    image_height_next  = image_height;
    bottom_up_next     = bottom_up;
    blue_byte_next     = blue_byte;
    green_byte_next    = green_byte;
    byte_in_pixel_next = byte_in_pixel;
    column_count_next  = column_count;
    row_count_next     = row_count;
    padding_left_next  = padding_left;
    res_valid          = 1'b0;
    res                = '0;
    do_pixel           = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        byte_position_next = byte_position + 1'b1;
        if (hdr_pos <= POS_SIG_LAST) begin
          signature_next[8*hdr_pos[0] +: 8] = file_byte;
        end else if (hdr_pos >= POS_OFFSET && hdr_pos <= POS_FILE_END) begin
          pixel_offset_next[8*(2'(hdr_pos - POS_OFFSET)) +: 8] = file_byte;
        end else if (hdr_pos >= POS_WIDTH && hdr_pos < POS_HEIGHT) begin
          raw_width_next[8*(2'(hdr_pos - POS_WIDTH)) +: 8] = file_byte;
        end else if (hdr_pos >= POS_HEIGHT && hdr_pos < POS_PLANES) begin
          raw_height_next[8*(2'(hdr_pos - POS_HEIGHT)) +: 8] = file_byte;
        end else if (hdr_pos >= POS_PLANES && hdr_pos < POS_DEPTH) begin
          planes_next[8*hdr_pos[0] +: 8] = file_byte;
        end else if (hdr_pos >= POS_DEPTH && hdr_pos < POS_COMPRESS) begin
          depth_next[8*hdr_pos[0] +: 8] = file_byte;
        end else if (hdr_pos >= POS_COMPRESS && hdr_pos < POS_COMPRESS + 6'd4) begin
          if (file_byte != '0) compressed_next = 1'b1;
        end

        if (hdr_pos == POS_FILE_END && signature != BMP_SIGNATURE) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res.status = ST_SIGNATURE;
        end else if (hdr_pos == POS_HEADER_END) begin
          if (hdr_code != ST_PIXEL) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res.status = hdr_code;
          end else begin
            phase_next        = PH_SKIP;
            image_width_next  = WB'(raw_width);
            image_height_next = HB'(height_mag);
            bottom_up_next    = ~raw_height[WORD_W-1];
          end
        end
      end
      PH_SKIP: begin
        if (byte_position != pixel_offset) begin
          byte_position_next = byte_position + 1'b1;
        end else begin
          phase_next = PH_PIXEL;
          do_pixel   = 1'b1;
        end
      end
      PH_PIXEL: begin
        do_pixel = 1'b1;
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (do_pixel) begin
      if (padding_left != '0) begin
        padding_left_next = padding_left - 1'b1;
        if (padding_left == 2'd1) begin
          row_count_next = row_inc;
          if (row_inc >= image_height) phase_next = PH_DONE;
        end
      end else if (byte_in_pixel == 2'd0) begin
        blue_byte_next     = file_byte;
        byte_in_pixel_next = 2'd1;
      end else if (byte_in_pixel == 2'd1) begin
        green_byte_next    = file_byte;
        byte_in_pixel_next = 2'd2;
      end else begin
        byte_in_pixel_next = 2'd0;
        res_valid          = 1'b1;
        res.status         = ST_PIXEL;
        res.pixel_white    = white;
        res.pixel_row      = COORD_W'(row_out);
        res.pixel_column   = COORD_W'(column_count);
        res.last_pixel     = (row_inc == image_height) && (column_inc == image_width);
        column_count_next  = column_inc;
        if (column_inc >= image_width) begin
          column_count_next = '0;
          // rows are padded to a multiple of four bytes
          padding_left_next = 2'(image_width);
          if (2'(image_width) == 2'd0) begin
            row_count_next = row_inc;
            if (row_inc >= image_height) phase_next = PH_DONE;
          end
        end
      end
    end

    if (end_of_file) begin
      if (phase_next == PH_HEADER) begin
        res_valid  = 1'b1;
        res        = '0;
        res.status = ST_SHORT_HDR;
      end else if (phase_next == PH_SKIP || phase_next == PH_PIXEL) begin
        res_valid  = 1'b1;
        res        = '0;
        res.status = ST_TRUNCATED;
      end
      // rearm for the next file
      phase_next         = PH_HEADER;
      byte_position_next = '0;
      pixel_offset_next  = '0;
      raw_width_next     = '0;
      raw_height_next    = '0;
      signature_next     = '0;
      planes_next        = '0;
      depth_next         = '0;
      compressed_next    = 1'b0;
      image_width_next   = '0;
      image_height_next  = '0;
      bottom_up_next     = 1'b0;
      blue_byte_next     = '0;
      green_byte_next    = '0;
      byte_in_pixel_next = '0;
      column_count_next  = '0;
      row_count_next     = '0;
      padding_left_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= '0;
      pixel_offset  <= '0;
      raw_width     <= '0;
      raw_height    <= '0;
      signature     <= '0;
      planes        <= '0;
      depth         <= '0;
      compressed    <= 1'b0;
      image_width   <= '0;
      image_height  <= '0;
      bottom_up     <= 1'b0;
      blue_byte     <= '0;
      green_byte    <= '0;
      byte_in_pixel <= '0;
      column_count  <= '0;
      row_count     <= '0;
      padding_left  <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      pixel_offset  <= pixel_offset_next;
      raw_width     <= raw_width_next;
      raw_height    <= raw_height_next;
      signature     <= signature_next;
      planes        <= planes_next;
      depth         <= depth_next;
      compressed    <= compressed_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      bottom_up     <= bottom_up_next;
      blue_byte     <= blue_byte_next;
      green_byte    <= green_byte_next;
      byte_in_pixel <= byte_in_pixel_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      padding_left  <= padding_left_next;
    end
  end
endmodule

// ===== src/bmp24_luminance_binarizer.sv =====
// Streaming 24-bit BMP binarizer. One file byte is taken per transfer and, while the
// result side does not stall, a new byte can be taken on every clock, so the block
// sustains one byte per cycle. A byte waits in the input register until the result
// register has room, is parsed together with the header/pixel counters, and its result
// (if any) lands in the result register. The step between the two registers is set by
// the parse state update plus the constant-coefficient luminance add and compare. Each
// completed BGR triple gives one pixel result with top-down row, column and a last-pixel
// flag; header errors and truncation give one status result; after a header error the
// block ignores bytes until end_of_file, which always rearms it. The threshold resets to
// 128; users write it through cfg_we/cfg_wdata while the stream is idle (not enforced).
module bmp24_luminance_binarizer #(
  parameter int MAX_WIDTH  = bmpbin_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpbin_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bmpbin_pkg::BYTE_W-1:0] cfg_wdata,
  bmpbin_in_if.sink                     file_stream,
  bmpbin_out_if.source                  result_stream
);
  import bmpbin_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eof;
  logic              out_valid;
  result_t           out_data;
  logic [LUMA_W-1:0] threshold_scaled;
  logic              advance;
  logic              res_valid;
  result_t           res;

  // held byte moves on once the result register has room
  assign advance           = in_valid && (!out_valid || result_stream.ready);
  assign file_stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_scaled <= LUMA_W'(THRESHOLD_RESET) * LUMA_W'(LUMA_SCALE);
    end else if (cfg_we) begin
      threshold_scaled <= LUMA_W'(cfg_wdata) * LUMA_W'(LUMA_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (file_stream.ready) begin
      in_valid <= file_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (file_stream.ready && file_stream.valid) begin
      in_byte <= file_stream.file_byte;
      in_eof  <= file_stream.end_of_file;
    end
  end

  bmpbin_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .file_byte        (in_byte),
    .end_of_file      (in_eof),
    .threshold_scaled (threshold_scaled),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (result_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  assign result_stream.valid        = out_valid;
  assign result_stream.status       = out_data.status;
  assign result_stream.pixel_white  = out_data.pixel_white;
  assign result_stream.pixel_row    = out_data.pixel_row;
  assign result_stream.pixel_column = out_data.pixel_column;
  assign result_stream.last_pixel   = out_data.last_pixel;
endmodule

// ===== src/bmpbin_checker.sv =====
// port-level checks on the binarizer, bound to the top level
module bmpbin_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [bmpbin_pkg::STATUS_W-1:0] status,
  input logic                            pixel_white,
  input logic [bmpbin_pkg::COORD_W-1:0]  pixel_row,
  input logic [bmpbin_pkg::COORD_W-1:0]  pixel_column,
  input logic                            last_pixel
);
  import bmpbin_pkg::*;

  // a result still waiting is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // error results carry no pixel information
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_PIXEL |->
      !pixel_white && pixel_row == '0 && pixel_column == '0 && !last_pixel)
    else $error("error result with pixel fields set");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= ST_TRUNCATED)
    else $error("status code out of range");

  // reset empties the result register and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");
endmodule

bind bmp24_luminance_binarizer bmpbin_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (file_stream.ready),
  .res_valid    (result_stream.valid),
  .res_ready    (result_stream.ready),
  .status       (result_stream.status),
  .pixel_white  (result_stream.pixel_white),
  .pixel_row    (result_stream.pixel_row),
  .pixel_column (result_stream.pixel_column),
  .last_pixel   (result_stream.last_pixel)
);

// ===== bench/tb_bmp24_luminance_binarizer.sv =====
// self-checking bench for the bmp binarizer: file streams in, pixels and status codes out
module tb_bmp24_luminance_binarizer;
  import bmpbin_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {PH_HDR, PH_SKIP, PH_PIXELS, PH_DONE, PH_LATCHED} parse_phase_t;

  class bmp_pixel_scoreboard;
    logic [7:0]   threshold;
    parse_phase_t phase;
    logic [31:0]  pos, pixel_start, img_w, img_h, col, row;
    logic [15:0]  sig, planes, depth;
    bit           compressed, bottom_up;
    logic [7:0]   blue_byte, green_byte;
    logic [1:0]   byte_slot, pad_left;
    result_t      due_results[$];
    int           errors;

    function new();
      threshold = THRESHOLD_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_HDR;
      pos = 0;
      pixel_start = 0;
      img_w = 0;
      img_h = 0;
      col = 0;
      row = 0;
      sig = 0;
      planes = 0;
      depth = 0;
      compressed = 0;
      bottom_up = 0;
      blue_byte = 0;
      green_byte = 0;
      byte_slot = 0;
      pad_left = 0;
    endfunction

    function void end_row();
      row++;
      if (row >= img_h) phase = PH_DONE;
    endfunction

    // works out what one accepted file byte produces
    function void note_byte(logic [7:0] b, logic eof);
      result_t     r;
      bit          have, take;
      logic [31:0] p, mag, out_row;
      int          lum;
      r = '0;
      have = 0;
      take = 0;
      case (phase)
        PH_HDR: begin
          p = pos;
          if (p <= POS_SIG_LAST) sig[8*p +: 8] = b;
          else if (p >= POS_OFFSET && p <= POS_FILE_END) pixel_start[8*(p-POS_OFFSET) +: 8] = b;
          else if (p >= POS_WIDTH && p < POS_HEIGHT) img_w[8*(p-POS_WIDTH) +: 8] = b;
          else if (p >= POS_HEIGHT && p < POS_PLANES) img_h[8*(p-POS_HEIGHT) +: 8] = b;
          else if (p >= POS_PLANES && p < POS_DEPTH) planes[8*(p-POS_PLANES) +: 8] = b;
          else if (p >= POS_DEPTH && p < POS_COMPRESS) depth[8*(p-POS_DEPTH) +: 8] = b;
          else if (p >= POS_COMPRESS && p < POS_COMPRESS + 4 && b != 0) compressed = 1;
          pos = p + 1;
          if (p == POS_FILE_END && sig != BMP_SIGNATURE) begin
            phase = PH_LATCHED;
            r.status = ST_SIGNATURE;
            have = 1;
          end else if (p == POS_HEADER_END) begin
            mag = img_h[31] ? -img_h : img_h;
            if (depth != BMP_DEPTH) r.status = ST_DEPTH;
            else if (compressed) r.status = ST_COMPRESSED;
            else if (planes != BMP_PLANES) r.status = ST_PLANES;
            else if (img_w < 1 || img_w > DEF_MAX_WIDTH) r.status = ST_SIZE;
            else if (mag < 1 || mag > DEF_MAX_HEIGHT) r.status = ST_SIZE;
            else if (pixel_start < HEADER_LEN) r.status = ST_OFFSET;
            if (r.status != ST_PIXEL) begin
              phase = PH_LATCHED;
              have = 1;
            end else begin
              // positive height means rows arrive bottom row first
              bottom_up = !img_h[31];
              img_h = mag;
              phase = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (pos != pixel_start) pos++;
          else begin
            phase = PH_PIXELS;
            take = 1;
          end
        end
        PH_PIXELS: take = 1;
        default: ;
      endcase

      if (take) begin
        if (pad_left != 0) begin
          pad_left--;
          if (pad_left == 0) end_row();
        end else if (byte_slot == 0) begin
          blue_byte = b;
          byte_slot = 1;
        end else if (byte_slot == 1) begin
          green_byte = b;
          byte_slot = 2;
        end else begin
          byte_slot = 0;
          lum = COEF_R * b + COEF_G * green_byte + COEF_B * blue_byte;
          out_row = bottom_up ? img_h - 1 - row : row;
          r.status = ST_PIXEL;
          r.pixel_white = lum >= int'(LUMA_SCALE) * int'(threshold);
          r.pixel_row = out_row[COORD_W-1:0];
          r.pixel_column = col[COORD_W-1:0];
          r.last_pixel = (row + 1 == img_h) && (col + 1 == img_w);
          have = 1;
          col++;
          if (col >= img_w) begin
            col = 0;
            pad_left = img_w[1:0];
            if (pad_left == 0) end_row();
          end
        end
      end

      // end of file rearms; an unfinished file reports instead of any pixel
      if (eof) begin
        if (phase == PH_HDR) begin
          r = '0;
          r.status = ST_SHORT_HDR;
          have = 1;
        end else if (phase == PH_SKIP || phase == PH_PIXELS) begin
          r = '0;
          r.status = ST_TRUNCATED;
          have = 1;
        end
        clear();
      end
      if (have) due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d row %0d column %0d", $time,
                 got.status, got.pixel_row, got.pixel_column);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("pixel_white", want.pixel_white, got.pixel_white);
      compare_field("pixel_row", want.pixel_row, got.pixel_row);
      compare_field("pixel_column", want.pixel_column, got.pixel_column);
      compare_field("last_pixel", want.last_pixel, got.last_pixel);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  bmpbin_in_if  file_if();
  bmpbin_out_if res_if();

  bmp24_luminance_binarizer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .file_stream(file_if),
    .result_stream(res_if)
  );

  bmp_pixel_scoreboard sb = new();

  logic [7:0] file_bytes[$];
  logic [7:0] cur_thr = THRESHOLD_RESET;
  bit         steady = 0;
  bit         hold_request = 0;
  int         bytes_sent = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_bmp24_luminance_binarizer: errors");
    $finish;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (!rst) begin
      if (file_if.valid && file_if.ready) sb.note_byte(file_if.file_byte, file_if.end_of_file);
      if (res_if.valid && res_if.ready) begin
        got = {res_if.status, res_if.pixel_white, res_if.pixel_row, res_if.pixel_column,
               res_if.last_pixel};
        sb.check_result(got);
      end
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        res_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 0;
      end else
        res_if.ready <= steady || $urandom_range(99) >= 8;
    end
  end

  function automatic logic [7:0] pix_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return cur_thr;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void trim(int n);
    if (file_bytes.size() > n) file_bytes = file_bytes[0:n-1];
  endfunction

  // header plus pixel rows, rows only when the header would pass and the gap is short
  function automatic void build_file(logic [15:0] sig, logic [31:0] off, logic [31:0] w,
                                     logic [31:0] h, logic [15:0] planes, logic [15:0] depth,
                                     logic [31:0] comp);
    logic [31:0] mag;
    bit          ok;
    mag = h[31] ? -h : h;
    ok = depth == BMP_DEPTH && comp == 0 && planes == BMP_PLANES && w >= 1 &&
         w <= DEF_MAX_WIDTH && mag >= 1 && mag <= DEF_MAX_HEIGHT && off >= HEADER_LEN;
    put_le(sig, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(off, 4);
    put_le(32'd40, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(planes, 2);
    put_le(depth, 2);
    put_le(comp, 4);
    repeat (5) put_le($urandom, 4);
    if (ok && off - HEADER_LEN <= 64) begin
      repeat (off - HEADER_LEN) file_bytes.push_back($urandom_range(255));
      for (int r = 0; r < mag; r++) begin
        for (int c = 0; c < 3 * w; c++) file_bytes.push_back(pix_byte());
        repeat (w & 3) file_bytes.push_back($urandom_range(255));
      end
    end
  endfunction

  function automatic void build_random_file();
    int          kind;
    logic [31:0] w, h, off, comp;
    logic [15:0] sig, planes, depth;
    kind = $urandom_range(99);
    w = $urandom_range(9, 1);
    h = $urandom_range(4, 1);
    if ($urandom_range(1)) h = -h;
    off = HEADER_LEN + $urandom_range(3);
    sig = BMP_SIGNATURE;
    planes = BMP_PLANES;
    depth = BMP_DEPTH;
    comp = 0;
    if (kind >= 95) begin
      repeat ($urandom_range(80, 1)) file_bytes.push_back($urandom_range(255));
      return;
    end
    if (kind >= 70 && kind < 85) begin
      case ($urandom_range(5))
        0: begin
          sig = $urandom_range(65535);
          if (sig == BMP_SIGNATURE) sig[0] = ~sig[0];
        end
        1: begin
          depth = $urandom_range(65535);
          if (depth == BMP_DEPTH) depth = 16'd32;
        end
        2: comp = 32'h1 << $urandom_range(31);
        3: planes = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 2));
        4: begin
          case ($urandom_range(3))
            0: w = 0;
            1: w = $urandom_range(32'hFFFF_FFFF, DEF_MAX_WIDTH + 1);
            2: h = 0;
            default: begin
              h = DEF_MAX_HEIGHT + 1 + $urandom_range(1000000);
              if ($urandom_range(1)) h = -h;
            end
          endcase
        end
        default: off = $urandom_range(53);
      endcase
    end
    build_file(sig, off, w, h, planes, depth, comp);
    if (kind < 85 && $urandom_range(2) == 0)
      repeat ($urandom_range(6, 1)) file_bytes.push_back($urandom_range(255));
    if (kind >= 85) trim($urandom_range(file_bytes.size(), 1));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(99) < 8) begin
      file_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    file_if.valid <= 1'b1;
    file_if.file_byte <= b;
    file_if.end_of_file <= last;
    @(posedge clk);
    while (!file_if.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // stop the stream and let every awaited result come out
  task automatic drain();
    file_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_threshold(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.threshold = v;
    cur_thr = v;
  endtask

  initial begin
    logic [7:0] levels[6];
    int         target;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    file_if.valid <= 1'b0;
    file_if.file_byte <= '0;
    file_if.end_of_file <= 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 bottom-up image, end of file on its padding byte
    build_file(BMP_SIGNATURE, 54, 1, 1, 1, 24, 0);
    send_file();
    // a lone byte is a short header
    file_bytes.push_back(8'h42);
    send_file();
    // bad signature, remaining header ignored
    build_file(16'h4D43, 54, 2, 2, 1, 24, 0);
    send_file();
    // bad signature with end of file on the same byte
    build_file(16'hB2BD, 54, 2, 2, 1, 24, 0);
    trim(14);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 2, 1, 32, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 2, 1, 24, 32'h8000_0000);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 2, 0, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 0, 2, 1, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 4097, 2, 1, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 0, 1, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, -32'sd4097, 1, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 32'h8000_0000, 1, 24, 0);
    send_file();
    build_file(BMP_SIGNATURE, 53, 2, 2, 1, 24, 0);
    send_file();
    // good header that ends the file on its last byte
    build_file(BMP_SIGNATURE, 54, 3, 2, 1, 24, 0);
    trim(54);
    send_file();
    // pixel data that can never be reached
    build_file(BMP_SIGNATURE, 32'hFFFF_FFFF, 2, 2, 1, 24, 0);
    repeat (5) file_bytes.push_back($urandom_range(255));
    send_file();
    // tallest bottom-up image, cut on the byte that finishes the third pixel
    build_file(BMP_SIGNATURE, 54, 1, 4096, 1, 24, 0);
    trim(65);
    send_file();
    // tallest top-down image, cut at the end of its second row
    build_file(BMP_SIGNATURE, 54, 4, -32'sd4096, 1, 24, 0);
    trim(54 + 24);
    send_file();
    // end of file on the byte that finishes the image
    build_file(BMP_SIGNATURE, 54, 4, -32'sd1, 1, 24, 0);
    send_file();
    // gap before the pixel data, then trailing bytes
    build_file(BMP_SIGNATURE, 57, 5, 3, 1, 24, 0);
    repeat (4) file_bytes.push_back($urandom_range(255));
    send_file();
    // one row while the result side holds off
    build_file(BMP_SIGNATURE, 54, 16, -32'sd1, 1, 24, 0);
    repeat (3) file_bytes.push_back($urandom_range(255));
    hold_request = 1;
    send_file();
    drain();

    levels = '{8'd0, 8'd255, 8'd127, 8'd1, 8'd254, 8'd0};
    levels[2] = $urandom_range(255);
    levels[5] = $urandom_range(255);
    foreach (levels[k]) begin
      set_threshold(levels[k]);
      steady = (k == 2);
      target = bytes_sent + 30;
      while (bytes_sent < target) begin
        build_random_file();
        send_file();
      end
      drain();
    end
    steady = 0;

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_bmp24_luminance_binarizer: clean");
    else
      $display("tb_bmp24_luminance_binarizer: errors");
    $finish;
  end

endmodule
